[hdl/tpqa_pkg.sv]
// Shared types and constants of the time-of-flight point qualifier and averager.
package tpqa_pkg;

    localparam int DIST_W    = 16;
    localparam int INT_W     = 16;
    localparam int MAXI_W    = 11;
    localparam int TIDX_W    = 10;
    localparam int TVAL_W    = 16;
    localparam int SUM_W     = 24;
    localparam int CNT_W     = 8;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    // Register map, word index into the APB space
    typedef enum logic [2:0] {
        REG_COMPENSATE_MODE   = 3'd0,
        REG_INT_LO            = 3'd1,
        REG_INT_HI            = 3'd2,
        REG_DIST_LO           = 3'd3,
        REG_DIST_HI           = 3'd4,
        REG_INVALID_DISTANCE  = 3'd5,
        REG_INVALID_INTENSITY = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic                compensate_mode;
        logic [INT_W-1:0]    int_lo;
        logic [MAXI_W-1:0]   int_hi;
        logic [DIST_W-1:0]   dist_lo;
        logic [DIST_W-1:0]   dist_hi;
        logic [DIST_W-1:0]   invalid_distance;
        logic [INT_W-1:0]    invalid_intensity;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_BEND,
        ST_BDIV,
        ST_SEND,
        ST_SDIV,
        ST_OUT
    } state_t;

endpackage

[hdl/tpqa_cfg_regs.sv]
// APB register file holding the qualifier bounds and the invalid-point values.
module tpqa_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpqa_pkg::APB_AW-1:0] paddr,
    input  logic [tpqa_pkg::APB_DW-1:0] pwdata,
    output logic [tpqa_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output tpqa_pkg::cfg_t              cfg
);
    import tpqa_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.compensate_mode   <= 1'b1;
            cfg_reg.int_lo            <= '0;
            cfg_reg.int_hi            <= MAXI_W'(1024);
            cfg_reg.dist_lo           <= '0;
            cfg_reg.dist_hi           <= '1;
            cfg_reg.invalid_distance  <= '1;
            cfg_reg.invalid_intensity <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_COMPENSATE_MODE:   cfg_reg.compensate_mode   <= pwdata[0];
                REG_INT_LO:            cfg_reg.int_lo            <= pwdata[INT_W-1:0];
                REG_INT_HI:            cfg_reg.int_hi            <= pwdata[MAXI_W-1:0];
                REG_DIST_LO:           cfg_reg.dist_lo           <= pwdata[DIST_W-1:0];
                REG_DIST_HI:           cfg_reg.dist_hi           <= pwdata[DIST_W-1:0];
                REG_INVALID_DISTANCE:  cfg_reg.invalid_distance  <= pwdata[DIST_W-1:0];
                REG_INVALID_INTENSITY: cfg_reg.invalid_intensity <= pwdata[INT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_COMPENSATE_MODE:   prdata = APB_DW'(cfg_reg.compensate_mode);
            REG_INT_LO:            prdata = APB_DW'(cfg_reg.int_lo);
            REG_INT_HI:            prdata = APB_DW'(cfg_reg.int_hi);
            REG_DIST_LO:           prdata = APB_DW'(cfg_reg.dist_lo);
            REG_DIST_HI:           prdata = APB_DW'(cfg_reg.dist_hi);
            REG_INVALID_DISTANCE:  prdata = APB_DW'(cfg_reg.invalid_distance);
            REG_INVALID_INTENSITY: prdata = APB_DW'(cfg_reg.invalid_intensity);
            default:               prdata = '0;
        endcase
    end

endmodule

[hdl/tpqa_serial_mod.sv]
// Bit-serial reduction of the intensity modulo the table depth, one bit per cycle.
module tpqa_serial_mod #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [tpqa_pkg::MAXI_W-1:0]    value,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] rem
);
    import tpqa_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int STEPW = $clog2(MAXI_W);

    logic [MAXI_W-1:0] bits_reg;
    logic [AW-1:0]     rem_reg;
    logic [STEPW-1:0]  step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [AW:0]       trial;
    logic [AW:0]       rem_next;

    always_comb begin
        trial = {rem_reg, bits_reg[MAXI_W-1]};
        if (trial >= (AW+1)'(TABLE_DEPTH)) begin
            rem_next = trial - (AW+1)'(TABLE_DEPTH);
        end else begin
            rem_next = trial;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEPW'(MAXI_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            bits_reg <= value;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            bits_reg <= {bits_reg[MAXI_W-2:0], 1'b0};
            rem_reg  <= rem_next[AW-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[hdl/tpqa_comp_table.sv]
// Compensation table memory with its clearing sweep after reset.
module tpqa_comp_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [tpqa_pkg::TIDX_W-1:0]    wr_index,
    input  logic [tpqa_pkg::TVAL_W-1:0]    wr_value,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output logic [tpqa_pkg::TVAL_W-1:0]    rd_data,
    output logic                           clear_busy
);
    import tpqa_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = (AW > TIDX_W) ? AW : TIDX_W;

    logic [TVAL_W-1:0] mem [TABLE_DEPTH];
    logic [TVAL_W-1:0] rd_data_reg;
    logic [AW:0]       clr_cnt_reg;
    logic              wr_ok;

    assign clear_busy = (clr_cnt_reg != (AW+1)'(TABLE_DEPTH));
    // loads beyond the table are dropped
    assign wr_ok      = wr_en && ((IW+1)'(wr_index) < (IW+1)'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (clear_busy) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear_busy) begin
            mem[clr_cnt_reg[AW-1:0]] <= '0;
        end else if (wr_ok) begin
            mem[AW'(wr_index)] <= wr_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/tpqa_serial_div.sv]
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
module tpqa_serial_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [tpqa_pkg::SUM_W-1:0] dividend_a,
    input  logic [tpqa_pkg::SUM_W-1:0] dividend_b,
    input  logic [tpqa_pkg::CNT_W-1:0] divisor,
    output logic                       done,
    output logic [tpqa_pkg::SUM_W-1:0] quot_a,
    output logic [tpqa_pkg::SUM_W-1:0] quot_b
);
    import tpqa_pkg::*;

    localparam int STEPW = $clog2(SUM_W);

    logic [SUM_W-1:0] q_reg   [2];
    logic [CNT_W-1:0] rem_reg [2];
    logic [SUM_W-1:0] q_next  [2];
    logic [CNT_W-1:0] rem_next[2];
    logic [CNT_W:0]   trial   [2];
    logic [CNT_W-1:0] dvs_reg;
    logic [STEPW-1:0] step_reg;
    logic             busy_reg;
    logic             done_reg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            trial[l] = {rem_reg[l], q_reg[l][SUM_W-1]};
            if (trial[l] >= {1'b0, dvs_reg}) begin
                rem_next[l] = CNT_W'(trial[l] - {1'b0, dvs_reg});
                q_next[l]   = {q_reg[l][SUM_W-2:0], 1'b1};
            end else begin
                rem_next[l] = trial[l][CNT_W-1:0];
                q_next[l]   = {q_reg[l][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEPW'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits shift in below
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg[0]   <= dividend_a;
            q_reg[1]   <= dividend_b;
            rem_reg[0] <= '0;
            rem_reg[1] <= '0;
            dvs_reg    <= divisor;
        end else if (busy_reg) begin
            for (int l = 0; l < 2; l++) begin
                q_reg[l]   <= q_next[l];
                rem_reg[l] <= rem_next[l];
            end
        end
    end

    assign done   = done_reg;
    assign quot_a = q_reg[0];
    assign quot_b = q_reg[1];

endmodule

[hdl/tof_point_qualify_average_unit.sv]
// Time-of-flight point qualifier and averager: screening, burst and series averaging.
// Load beats go straight into the table. A compensated sample beat runs the 11-step serial
// modulo of the intensity, then a registered table read. A burst end with valid points
// runs the 24-step bit-serial divider, as does a series end with averaged bursts, which
// then waits for the output handoff. Reset is synchronous, active low; afterwards the
// table is swept to zero with s_tready low. Config writes are taken throughout.
module tof_point_qualify_average_unit #(
    parameter int TABLE_DEPTH       = 1024,
    parameter int MAX_BURST_POINTS  = 64,
    parameter int MAX_SERIES_BURSTS = 255
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // tdata: table_index[9:0], table_value[25:10], sample_distance[41:26],
    //        sample_intensity[57:42], zero fill
    input  logic [tpqa_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: func[0], series_end[1]
    input  logic [tpqa_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // tdata: avg_distance[15:0], avg_intensity[31:16]
    output logic [tpqa_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser: point_valid[0]
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpqa_pkg::APB_AW-1:0]   paddr,
    input  logic [tpqa_pkg::APB_DW-1:0]   pwdata,
    output logic [tpqa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import tpqa_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [DIST_W-1:0] dist_reg;
    logic [INT_W-1:0]  itst_reg;
    logic              bend_reg;
    logic              send_reg;

    logic [SUM_W-1:0]  bsum_d_reg, bsum_i_reg, ssum_d_reg, ssum_i_reg;
    logic [CNT_W-1:0]  bvc_reg, bsc_reg, svc_reg;

    logic [DIST_W-1:0] res_d_reg;
    logic [INT_W-1:0]  res_i_reg;
    logic              res_v_reg;
    logic [DIST_W-1:0] out_d_reg;
    logic [INT_W-1:0]  out_i_reg;
    logic              out_v_reg;
    logic              m_tvalid_reg;

    logic              acc;
    logic              in_func, in_send, in_bend;
    logic [DIST_W-1:0] in_dist;
    logic [INT_W-1:0]  in_itst;

    logic              mod_start, mod_done;
    logic [AW-1:0]     mod_rem;
    logic [TVAL_W-1:0] comp_val;
    logic              clear_busy;

    logic              div_start, div_done, div_series;
    logic [SUM_W-1:0]  quot_d, quot_i;

    logic              int_ok, dist_ok, sample_ok;
    logic [DIST_W-1:0] eff_dist;
    logic              burst_room, series_room, out_free;
    logic              do_check, do_bclear, do_badd, do_sres, do_invalid, load_out;

    assign in_func = s_tuser[0];
    assign in_send = s_tuser[1];
    assign in_bend = s_tlast || in_send;
    assign in_dist = s_tdata[41:26];
    assign in_itst = s_tdata[57:42];
    assign acc     = s_tvalid && s_tready;

    tpqa_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tpqa_serial_mod #(.TABLE_DEPTH(TABLE_DEPTH)) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .value   (in_itst[MAXI_W-1:0]),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    tpqa_comp_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (acc && !in_func),
        .wr_index   (s_tdata[9:0]),
        .wr_value   (s_tdata[25:10]),
        .rd_addr    (mod_rem),
        .rd_data    (comp_val),
        .clear_busy (clear_busy)
    );

    tpqa_serial_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .dividend_a (div_series ? ssum_d_reg : bsum_d_reg),
        .dividend_b (div_series ? ssum_i_reg : bsum_i_reg),
        .divisor    (div_series ? svc_reg : bvc_reg),
        .done       (div_done),
        .quot_a     (quot_d),
        .quot_b     (quot_i)
    );

    // Screening of the latched sample
    assign int_ok    = (itst_reg >= cfg.int_lo) &&
                       (itst_reg < INT_W'(cfg.int_hi));
    assign eff_dist  = cfg.compensate_mode ? (dist_reg - comp_val) : dist_reg;
    assign dist_ok   = (eff_dist >= cfg.dist_lo) && (eff_dist < cfg.dist_hi);
    assign sample_ok = int_ok && dist_ok;

    assign burst_room  = bsc_reg < CNT_W'(MAX_BURST_POINTS);
    assign series_room = (bvc_reg != '0) && (svc_reg < CNT_W'(MAX_SERIES_BURSTS));
    assign out_free    = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc && in_func) begin
                    if (burst_room) begin
                        state_next = cfg.compensate_mode ? ST_MOD : ST_CHECK;
                    end else if (in_bend) begin
                        state_next = ST_BEND;
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: state_next = bend_reg ? ST_BEND : ST_IDLE;
            ST_BEND: begin
                if (series_room) begin
                    state_next = ST_BDIV;
                end else begin
                    state_next = send_reg ? ST_SEND : ST_IDLE;
                end
            end
            ST_BDIV: begin
                if (div_done) begin
                    state_next = send_reg ? ST_SEND : ST_IDLE;
                end
            end
            ST_SEND: state_next = (svc_reg != '0) ? ST_SDIV : ST_OUT;
            ST_SDIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        mod_start  = 1'b0;
        div_start  = 1'b0;
        div_series = 1'b0;
        do_check   = 1'b0;
        do_bclear  = 1'b0;
        do_badd    = 1'b0;
        do_sres    = 1'b0;
        do_invalid = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = !clear_busy;
                mod_start = acc && in_func && burst_room && cfg.compensate_mode;
            end
            ST_MOD:   ;
            ST_CHECK: do_check = 1'b1;
            ST_BEND: begin
                div_start = series_room;
                do_bclear = !series_room;
            end
            ST_BDIV: begin
                do_badd   = div_done;
                do_bclear = div_done;
            end
            ST_SEND: begin
                div_series = 1'b1;
                div_start  = (svc_reg != '0);
                do_invalid = (svc_reg == '0);
            end
            ST_SDIV:  do_sres = div_done;
            ST_OUT:   load_out = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bsum_d_reg   <= '0;
            bsum_i_reg   <= '0;
            bvc_reg      <= '0;
            bsc_reg      <= '0;
            ssum_d_reg   <= '0;
            ssum_i_reg   <= '0;
            svc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (do_check) begin
                bsc_reg <= bsc_reg + 1'b1;
                if (sample_ok) begin
                    bsum_d_reg <= bsum_d_reg + SUM_W'(eff_dist);
                    bsum_i_reg <= bsum_i_reg + SUM_W'(itst_reg);
                    bvc_reg    <= bvc_reg + 1'b1;
                end
            end
            if (do_bclear) begin
                bsum_d_reg <= '0;
                bsum_i_reg <= '0;
                bvc_reg    <= '0;
                bsc_reg    <= '0;
            end
            if (do_badd) begin
                ssum_d_reg <= ssum_d_reg + quot_d;
                ssum_i_reg <= ssum_i_reg + quot_i;
                svc_reg    <= svc_reg + 1'b1;
            end
            if (load_out) begin
                ssum_d_reg   <= '0;
                ssum_i_reg   <= '0;
                svc_reg      <= '0;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            dist_reg <= in_dist;
            itst_reg <= in_itst;
            bend_reg <= in_bend;
            send_reg <= in_send;
        end
        if (do_sres) begin
            res_d_reg <= quot_d[DIST_W-1:0];
            res_i_reg <= quot_i[INT_W-1:0];
            res_v_reg <= 1'b1;
        end else if (do_invalid) begin
            res_d_reg <= cfg.invalid_distance;
            res_i_reg <= cfg.invalid_intensity;
            res_v_reg <= 1'b0;
        end
        if (load_out) begin
            out_d_reg <= res_d_reg;
            out_i_reg <= res_i_reg;
            out_v_reg <= res_v_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_i_reg, out_d_reg};
    assign m_tuser  = out_v_reg;

endmodule
